FILE: src/mpxp_pkg.sv
// Shared constants and the result record type of the multiplexing header parser.
`timescale 1ns / 1ps

package mpxp_pkg;

  // Width of the saturating payload byte counter.
  localparam int LENGTH_BITS = 16;

  // Width of the payload_length result field.
  localparam int PAY_LEN_W = 16;

  // Depth of the result queue; must be a power of two.
  localparam int FIFO_DEPTH = 4;

  // Control byte fields.
  localparam logic [7:0] TYPE_MASK = 8'b0000_0111;
  localparam logic [7:0] TID_MASK  = 8'b1111_1000;

  // Transfer type codes.
  localparam logic [2:0] TT_FULL       = 3'd0;
  localparam logic [2:0] TT_FULL_SMALL = 3'd1;
  localparam logic [2:0] TT_FRAG       = 3'd2;
  localparam logic [2:0] TT_FRAG_LAST  = 3'd4;
  localparam logic [2:0] TT_ABORT      = 3'd6;

  // Result kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic                 item_kind;
    logic [7:0]           payload_byte;
    logic [2:0]           xfer_type;
    logic [4:0]           trans_id;
    logic [7:0]           frag_no;
    logic [15:0]          total_size;
    logic [15:0]          mux_ident;
    logic [PAY_LEN_W-1:0] payload_length;
    logic                 parse_ok;
    logic                 final_item;
  } result_t;

endpackage

FILE: src/mpxp_parser.sv
// Header phase tracker that turns one byte into up to two result records.
`timescale 1ns / 1ps

module mpxp_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output logic              pay_valid,
  output logic              sum_valid,
  output mpxp_pkg::result_t pay_res,
  output mpxp_pkg::result_t sum_res
);

  localparam logic [2:0] PH_CTRL    = 3'd0;
  localparam logic [2:0] PH_FRAG    = 3'd1;
  localparam logic [2:0] PH_TOT_LO  = 3'd2;
  localparam logic [2:0] PH_TOT_HI  = 3'd3;
  localparam logic [2:0] PH_MUX_LO  = 3'd4;
  localparam logic [2:0] PH_MUX_HI  = 3'd5;
  localparam logic [2:0] PH_PAYLOAD = 3'd6;
  localparam logic [2:0] PH_DISCARD = 3'd7;

  localparam logic [32:0] LEN_MAX = 33'((64'd1 << mpxp_pkg::PAY_LEN_W) - 64'd1);

  logic [2:0]                       phase, phase_next;
  logic [2:0]                       saw_type, saw_type_next;
  logic [4:0]                       saw_transaction, saw_transaction_next;
  logic [7:0]                       saw_fragment, saw_fragment_next;
  logic [15:0]                      saw_total, saw_total_next;
  logic [15:0]                      saw_mux, saw_mux_next;
  logic                             need_mux, need_mux_next;
  logic [mpxp_pkg::LENGTH_BITS-1:0] payload_count, payload_count_next;
  logic                             error_seen, error_seen_next;

  // Values after this byte's header step, before the end-of-element cleanup.
  logic [2:0]                       ph_mid;
  logic [2:0]                       type_mid;
  logic [4:0]                       tid_mid;
  logic [7:0]                       frag_mid;
  logic [15:0]                      tot_mid;
  logic [15:0]                      mux_mid;
  logic                             need_mid;
  logic [mpxp_pkg::LENGTH_BITS-1:0] cnt_mid;
  logic                             err_mid;
  logic                             header_due;
  logic [32:0]                      cnt_ext;

  always_comb begin
    ph_mid    = phase;
    type_mid  = saw_type;
    tid_mid   = saw_transaction;
    frag_mid  = saw_fragment;
    tot_mid   = saw_total;
    mux_mid   = saw_mux;
    need_mid  = need_mux;
    cnt_mid   = payload_count;
    err_mid   = error_seen;
    pay_valid = 1'b0;

    unique case (phase)
      PH_CTRL: begin
        type_mid = data_byte[2:0] & mpxp_pkg::TYPE_MASK[2:0];
        tid_mid  = 5'((data_byte & mpxp_pkg::TID_MASK) >> 3);
        unique case (type_mid)
          mpxp_pkg::TT_FULL:       ph_mid = PH_MUX_LO;
          mpxp_pkg::TT_FULL_SMALL: ph_mid = PH_PAYLOAD;
          mpxp_pkg::TT_FRAG,
          mpxp_pkg::TT_FRAG_LAST:  ph_mid = PH_FRAG;
          mpxp_pkg::TT_ABORT: begin
            need_mid = 1'b0;
            ph_mid   = last_byte ? PH_PAYLOAD : PH_TOT_LO;
          end
          default: begin
            err_mid = 1'b1;
            ph_mid  = PH_DISCARD;
          end
        endcase
      end
      PH_FRAG: begin
        frag_mid = data_byte;
        if (data_byte == 8'd0) begin
          need_mid = 1'b1;
          ph_mid   = PH_TOT_LO;
        end else begin
          ph_mid = PH_PAYLOAD;
        end
      end
      PH_TOT_LO: begin
        tot_mid = {8'd0, data_byte};
        ph_mid  = PH_TOT_HI;
      end
      PH_TOT_HI: begin
        tot_mid = {data_byte, saw_total[7:0]};
        ph_mid  = need_mux ? PH_MUX_LO : PH_PAYLOAD;
      end
      PH_MUX_LO: begin
        mux_mid = {8'd0, data_byte};
        ph_mid  = PH_MUX_HI;
      end
      PH_MUX_HI: begin
        mux_mid = {data_byte, saw_mux[7:0]};
        ph_mid  = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        pay_valid = 1'b1;
        if (payload_count != '1) begin
          cnt_mid = payload_count + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign header_due = (ph_mid != PH_PAYLOAD) && (ph_mid != PH_DISCARD);
  assign cnt_ext    = 33'(cnt_mid);
  assign sum_valid  = last_byte;

  always_comb begin
    pay_res              = '0;
    pay_res.item_kind    = mpxp_pkg::KIND_PAYLOAD;
    pay_res.payload_byte = data_byte;

    sum_res                = '0;
    sum_res.item_kind      = mpxp_pkg::KIND_SUMMARY;
    sum_res.xfer_type      = type_mid;
    sum_res.trans_id       = tid_mid;
    sum_res.frag_no        = frag_mid;
    // A 16-bit field with only its low byte seen reads as zero.
    sum_res.total_size     = (ph_mid == PH_TOT_HI) ? 16'd0 : tot_mid;
    sum_res.mux_ident      = (ph_mid == PH_MUX_HI) ? 16'd0 : mux_mid;
    sum_res.payload_length = (cnt_ext > LEN_MAX) ? LEN_MAX[mpxp_pkg::PAY_LEN_W-1:0]
                                                 : cnt_ext[mpxp_pkg::PAY_LEN_W-1:0];
    sum_res.parse_ok       = !(err_mid || header_due);
    sum_res.final_item     = 1'b1;
  end

  always_comb begin
    if (last_byte) begin
      phase_next           = PH_CTRL;
      saw_type_next        = '0;
      saw_transaction_next = '0;
      saw_fragment_next    = '0;
      saw_total_next       = '0;
      saw_mux_next         = '0;
      need_mux_next        = 1'b0;
      payload_count_next   = '0;
      error_seen_next      = 1'b0;
    end else begin
      phase_next           = ph_mid;
      saw_type_next        = type_mid;
      saw_transaction_next = tid_mid;
      saw_fragment_next    = frag_mid;
      saw_total_next       = tot_mid;
      saw_mux_next         = mux_mid;
      need_mux_next        = need_mid;
      payload_count_next   = cnt_mid;
      error_seen_next      = err_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_CTRL;
      saw_type        <= '0;
      saw_transaction <= '0;
      saw_fragment    <= '0;
      saw_total       <= '0;
      saw_mux         <= '0;
      need_mux        <= 1'b0;
      payload_count   <= '0;
      error_seen      <= 1'b0;
    end else if (fire) begin
      phase           <= phase_next;
      saw_type        <= saw_type_next;
      saw_transaction <= saw_transaction_next;
      saw_fragment    <= saw_fragment_next;
      saw_total       <= saw_total_next;
      saw_mux         <= saw_mux_next;
      need_mux        <= need_mux_next;
      payload_count   <= payload_count_next;
      error_seen      <= error_seen_next;
    end
  end

endmodule

FILE: src/mpxp_out_fifo.sv
// Queue taking up to two results a cycle and giving one unless stalled.
`timescale 1ns / 1ps

module mpxp_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push0,
  input  logic              push1,
  input  mpxp_pkg::result_t data0,
  input  mpxp_pkg::result_t data1,
  output logic              room_two,
  output logic              res_valid,
  input  logic              res_stall,
  output mpxp_pkg::result_t head
);

  localparam int AW = $clog2(mpxp_pkg::FIFO_DEPTH);
  localparam int CW = $clog2(mpxp_pkg::FIFO_DEPTH + 1);

  mpxp_pkg::result_t entries [mpxp_pkg::FIFO_DEPTH];

  logic [AW-1:0] wr_ptr, wr_ptr_next;
  logic [AW-1:0] rd_ptr, rd_ptr_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] wr_ptr_plus1;
  logic          pop;
  logic [1:0]    n_push;

  assign pop          = res_valid && !res_stall;
  assign n_push       = {1'b0, push0} + {1'b0, push0 && push1};
  assign wr_ptr_plus1 = AW'(wr_ptr + 1'b1);
  assign wr_ptr_next  = AW'(wr_ptr + AW'(n_push));
  assign rd_ptr_next  = pop ? AW'(rd_ptr + 1'b1) : rd_ptr;
  assign count_next   = CW'(count + CW'(n_push) - CW'(pop));
  assign room_two     = count <= CW'(mpxp_pkg::FIFO_DEPTH - 2);
  assign res_valid    = count != '0;
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      entries[wr_ptr] <= data0;
    end
    if (push0 && push1) begin
      entries[wr_ptr_plus1] <= data1;
    end
  end

endmodule

FILE: src/mpx_header_parser.sv
// Top level of the multiplexing information element header parser.
`timescale 1ns / 1ps

//  Channel  | Handshake              | Fields
//  ---------+------------------------+------------------------------------------
//  byte in  | byte_valid, byte_stall | data_byte, last_byte
//  result   | res_valid, res_stall   | item_kind, payload_byte, xfer_type,
//           |                        | trans_id, frag_no,
//           |                        | total_size, mux_ident,
//           |                        | payload_length, parse_ok, final_item
//
// One byte is taken per cycle while byte_stall is low. A byte waits in the input
// register until the queue has room for two items; the phase logic then turns it
// into zero, one or two result items written to a four-entry result queue, so its
// results are offered from the queue. The result port drains one item per cycle
// while res_stall is low; a byte that ends the element with a payload byte yields
// two items. Reset is synchronous and clears the phase state, the input register and
// the queue. A stall on the result side fills the queue and then stalls the input.

module mpx_header_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        res_valid,
  input  logic        res_stall,
  output logic        item_kind,
  output logic [7:0]  payload_byte,
  output logic [2:0]  xfer_type,
  output logic [4:0]  trans_id,
  output logic [7:0]  frag_no,
  output logic [15:0] total_size,
  output logic [15:0] mux_ident,
  output logic [mpxp_pkg::PAY_LEN_W-1:0] payload_length,
  output logic        parse_ok,
  output logic        final_item
);

  // Input register.
  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       hold_last;

  logic              fire;
  logic              room_two;
  logic              byte_take;
  logic              pay_valid;
  logic              sum_valid;
  mpxp_pkg::result_t pay_res;
  mpxp_pkg::result_t sum_res;
  logic              push0;
  logic              push1;
  mpxp_pkg::result_t data0;
  mpxp_pkg::result_t head;

  // The held byte is worked on once the queue has room for both of its results.
  assign fire       = hold_valid && room_two;
  assign byte_stall = hold_valid && !fire;
  assign byte_take  = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (byte_take) begin
      hold_valid <= 1'b1;
    end else if (fire) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_take) begin
      hold_byte <= data_byte;
      hold_last <= last_byte;
    end
  end

  mpxp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .data_byte (hold_byte),
    .last_byte (hold_last),
    .pay_valid (pay_valid),
    .sum_valid (sum_valid),
    .pay_res   (pay_res),
    .sum_res   (sum_res)
  );

  // A payload item always goes ahead of the summary of the same byte.
  assign push0 = fire && (pay_valid || sum_valid);
  assign push1 = fire && pay_valid && sum_valid;
  assign data0 = pay_valid ? pay_res : sum_res;

  mpxp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push0     (push0),
    .push1     (push1),
    .data0     (data0),
    .data1     (sum_res),
    .room_two  (room_two),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .head      (head)
  );

  assign item_kind      = head.item_kind;
  assign payload_byte   = head.payload_byte;
  assign xfer_type      = head.xfer_type;
  assign trans_id       = head.trans_id;
  assign frag_no        = head.frag_no;
  assign total_size     = head.total_size;
  assign mux_ident      = head.mux_ident;
  assign payload_length = head.payload_length;
  assign parse_ok       = head.parse_ok;
  assign final_item     = head.final_item;

endmodule

FILE: bench/tb.sv
// Self-checking testbench for the multiplexing information element header parser.
`timescale 1ns / 1ps

module tb;

  // The run is cut off here.
  localparam int LIMIT_CYCLES = 1_000_000;
  // Results pass the input register and the queue before they are offered; this tail lets the block settle.
  localparam int DRAIN_CYCLES = 10;
  // Length of the long receiver hold-off in the backpressure test.
  localparam int HOLD_CYCLES  = 200;

  // Valid transfer types and the codes that the parser must reject.
  localparam logic [2:0] TT_VALID [5] = '{mpxp_pkg::TT_FULL, mpxp_pkg::TT_FULL_SMALL,
                                          mpxp_pkg::TT_FRAG, mpxp_pkg::TT_FRAG_LAST,
                                          mpxp_pkg::TT_ABORT};
  localparam logic [2:0] TT_UNKNOWN [3] = '{3'd3, 3'd5, 3'd7};

  // Header parsing phases, in the order the fields can appear.
  localparam logic [2:0] ST_CTRL    = 3'd0;
  localparam logic [2:0] ST_FRAG    = 3'd1;
  localparam logic [2:0] ST_TOT_LO  = 3'd2;
  localparam logic [2:0] ST_TOT_HI  = 3'd3;
  localparam logic [2:0] ST_MUX_LO  = 3'd4;
  localparam logic [2:0] ST_MUX_HI  = 3'd5;
  localparam logic [2:0] ST_PAYLOAD = 3'd6;
  localparam logic [2:0] ST_DISCARD = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                           byte_valid = 1'b0;
  logic                           byte_stall;
  logic [7:0]                     data_byte  = 8'h00;
  logic                           last_byte  = 1'b0;
  logic                           res_valid;
  logic                           res_stall  = 1'b0;
  logic                           item_kind;
  logic [7:0]                     payload_byte;
  logic [2:0]                     xfer_type;
  logic [4:0]                     trans_id;
  logic [7:0]                     frag_no;
  logic [15:0]                    total_size;
  logic [15:0]                    mux_ident;
  logic [mpxp_pkg::PAY_LEN_W-1:0] payload_length;
  logic                           parse_ok;
  logic                           final_item;

  // Idling knobs, in percent of cycles, and the long hold-off counter.
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_left     = 0;

  int cycles     = 0;
  int mismatches = 0;

  // Results the parser owes us, oldest first.
  mpxp_pkg::result_t parsed_q[$];

  // Bytes of the element being sent; the last one carries the end flag.
  logic [7:0] elem[$];

  // Shadow of the parser state.
  logic [2:0]                       hp;
  logic [2:0]                       hv_type;
  logic [4:0]                       hv_tid;
  logic [7:0]                       hv_frag;
  logic [15:0]                      hv_total;
  logic [15:0]                      hv_mux;
  logic                             hv_need_mux;
  logic [mpxp_pkg::LENGTH_BITS-1:0] hv_count;
  logic                             hv_bad;

  always #5 clk = ~clk;

  mpx_header_parser i_dut (
    .clk            (clk),
    .rst            (rst),
    .byte_valid     (byte_valid),
    .byte_stall     (byte_stall),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .item_kind      (item_kind),
    .payload_byte   (payload_byte),
    .xfer_type      (xfer_type),
    .trans_id       (trans_id),
    .frag_no        (frag_no),
    .total_size     (total_size),
    .mux_ident      (mux_ident),
    .payload_length (payload_length),
    .parse_ok       (parse_ok),
    .final_item     (final_item)
  );

  // Returns the shadow state to its condition at the start of an element.
  function automatic void clear_parse();
    hp          = ST_CTRL;
    hv_type     = '0;
    hv_tid      = '0;
    hv_frag     = '0;
    hv_total    = '0;
    hv_mux      = '0;
    hv_need_mux = 1'b0;
    hv_count    = '0;
    hv_bad      = 1'b0;
  endfunction

  initial clear_parse();

  // Advances the shadow state by one accepted byte and queues the results it owes.
  function automatic void parse_byte(input logic [7:0] b, input logic is_last);
    mpxp_pkg::result_t r;
    r = '0;
    unique case (hp)
      ST_CTRL: begin
        hv_type = 3'(b & mpxp_pkg::TYPE_MASK);
        hv_tid  = 5'((b & mpxp_pkg::TID_MASK) >> 3);
        unique case (hv_type)
          mpxp_pkg::TT_FULL:       hp = ST_MUX_LO;
          mpxp_pkg::TT_FULL_SMALL: hp = ST_PAYLOAD;
          mpxp_pkg::TT_FRAG,
          mpxp_pkg::TT_FRAG_LAST:  hp = ST_FRAG;
          mpxp_pkg::TT_ABORT: begin
            // An abort carries its total size only when more bytes follow.
            hv_need_mux = 1'b0;
            hp = is_last ? ST_PAYLOAD : ST_TOT_LO;
          end
          default: begin
            hv_bad = 1'b1;
            hp = ST_DISCARD;
          end
        endcase
      end
      ST_FRAG: begin
        hv_frag = b;
        if (b == 8'h00) begin
          // The first fragment also carries total size and multiplex id.
          hv_need_mux = 1'b1;
          hp = ST_TOT_LO;
        end else begin
          hp = ST_PAYLOAD;
        end
      end
      ST_TOT_LO: begin
        hv_total = {8'h00, b};
        hp = ST_TOT_HI;
      end
      ST_TOT_HI: begin
        hv_total[15:8] = b;
        hp = hv_need_mux ? ST_MUX_LO : ST_PAYLOAD;
      end
      ST_MUX_LO: begin
        hv_mux = {8'h00, b};
        hp = ST_MUX_HI;
      end
      ST_MUX_HI: begin
        hv_mux[15:8] = b;
        hp = ST_PAYLOAD;
      end
      ST_PAYLOAD: begin
        r.item_kind    = mpxp_pkg::KIND_PAYLOAD;
        r.payload_byte = b;
        // The byte counter sticks at its top value.
        if (hv_count != '1) hv_count = hv_count + 1'b1;
        parsed_q.push_back(r);
      end
      default: ;
    endcase

    if (is_last) begin
      // Ending inside the header is an error; a half-received 16-bit field reads 0.
      if (hp != ST_PAYLOAD && hp != ST_DISCARD) begin
        hv_bad = 1'b1;
        if (hp == ST_TOT_HI) hv_total = '0;
        if (hp == ST_MUX_HI) hv_mux = '0;
      end
      r = '0;
      r.item_kind      = mpxp_pkg::KIND_SUMMARY;
      r.xfer_type      = hv_type;
      r.trans_id       = hv_tid;
      r.frag_no        = hv_frag;
      r.total_size     = hv_total;
      r.mux_ident      = hv_mux;
      r.payload_length = (64'(hv_count) > 64'hFFFF) ? '1
                                                     : mpxp_pkg::PAY_LEN_W'(hv_count);
      r.parse_ok       = !hv_bad;
      r.final_item     = 1'b1;
      parsed_q.push_back(r);
      clear_parse();
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got_v,
                                 input logic [15:0] want_v);
    mismatches++;
    $display("mismatch at cycle %0d: %s is %0h, expected %0h", cycles, what, got_v, want_v);
  endtask

  // Result checker: every accepted result is held against the oldest owed one.
  always @(posedge clk) begin
    mpxp_pkg::result_t got;
    mpxp_pkg::result_t want;
    if (!rst && res_valid && !res_stall) begin
      got = {item_kind, payload_byte, xfer_type, trans_id, frag_no,
             total_size, mux_ident, payload_length, parse_ok, final_item};
      if (parsed_q.size() == 0) begin
        report_mismatch("result with nothing owed, item_kind", 16'(got.item_kind), 16'h0);
      end else begin
        want = parsed_q.pop_front();
        if (got.item_kind !== want.item_kind)
          report_mismatch("item_kind", 16'(got.item_kind), 16'(want.item_kind));
        if (got.payload_byte !== want.payload_byte)
          report_mismatch("payload_byte", 16'(got.payload_byte), 16'(want.payload_byte));
        if (got.xfer_type !== want.xfer_type)
          report_mismatch("xfer_type", 16'(got.xfer_type), 16'(want.xfer_type));
        if (got.trans_id !== want.trans_id)
          report_mismatch("trans_id", 16'(got.trans_id), 16'(want.trans_id));
        if (got.frag_no !== want.frag_no)
          report_mismatch("frag_no", 16'(got.frag_no), 16'(want.frag_no));
        if (got.total_size !== want.total_size)
          report_mismatch("total_size", got.total_size, want.total_size);
        if (got.mux_ident !== want.mux_ident)
          report_mismatch("mux_ident", got.mux_ident, want.mux_ident);
        if (got.payload_length !== want.payload_length)
          report_mismatch("payload_length", 16'(got.payload_length), 16'(want.payload_length));
        if (got.parse_ok !== want.parse_ok)
          report_mismatch("parse_ok", 16'(got.parse_ok), 16'(want.parse_ok));
        if (got.final_item !== want.final_item)
          report_mismatch("final_item", 16'(got.final_item), 16'(want.final_item));
      end
    end
  end

  // Receiver: a long hold-off takes precedence over the random stall pattern.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      res_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      res_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: a hung block ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offers one byte, with random idle cycles ahead of it, and waits until it is taken.
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    data_byte  <= b;
    last_byte  <= is_last;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    parse_byte(b, is_last);
  endtask

  task automatic send_element();
    foreach (elem[i]) send_byte(elem[i], i == elem.size() - 1);
  endtask

  // The sender stops until every owed result has come back, then lets the block settle.
  task automatic wait_drained();
    byte_valid <= 1'b0;
    do @(posedge clk); while (parsed_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Well-formed headers of the full and fragment types, with extreme ids, bytes and fragment numbers.
  task automatic test_header_types();
    elem = {{5'h1F, mpxp_pkg::TT_FULL}, 8'h34, 8'h12, 8'h00, 8'hFF};
    send_element();
    // A bare control byte: small full frame with no payload at all.
    elem = {{5'h00, mpxp_pkg::TT_FULL_SMALL}};
    send_element();
    // First fragment: fragment 0, total size and multiplex id, then one byte.
    elem = {{5'h15, mpxp_pkg::TT_FRAG}, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'hA5};
    send_element();
    elem = {{5'h0A, mpxp_pkg::TT_FRAG_LAST}, 8'hFF};
    send_element();
    wait_drained();
  endtask

  // Abort alone is complete; abort with only one total size byte is not.
  task automatic test_abort_forms();
    elem = {{5'h07, mpxp_pkg::TT_ABORT}};
    send_element();
    elem = {{5'h18, mpxp_pkg::TT_ABORT}, 8'h5A};
    send_element();
    wait_drained();
  endtask

  // Unknown types drop the rest of the element and report an error.
  task automatic test_unknown_types();
    elem = {{5'h09, TT_UNKNOWN[2]}, 8'hC3};
    send_element();
    elem = {{5'h1F, TT_UNKNOWN[0]}};
    send_element();
    elem = {{5'h01, TT_UNKNOWN[1]}};
    send_element();
    wait_drained();
  endtask

  // Elements that end with a 16-bit header field half received.
  task automatic test_early_end();
    elem = {{5'h03, mpxp_pkg::TT_FULL}, 8'h77};
    send_element();
    elem = {{5'h11, mpxp_pkg::TT_FRAG}, 8'h00, 8'h42};
    send_element();
    wait_drained();
  endtask

  // One element with a long payload, counted into a single summary.
  task automatic test_long_payload();
    elem = {{5'h1E, mpxp_pkg::TT_FULL_SMALL}};
    repeat (40) elem.push_back(8'($urandom));
    send_element();
    wait_drained();
  endtask

  // The receiver holds off long enough for the result queue to fill and stall the input.
  task automatic test_backpressure();
    @(negedge clk);
    hold_left = HOLD_CYCLES;
    @(posedge clk);
    elem = {{5'h0C, mpxp_pkg::TT_FULL_SMALL}};
    repeat (60) elem.push_back(8'($urandom));
    send_element();
    wait_drained();
  endtask

  // Mostly well-formed elements with random content; some unknown types and cut-off ones.
  task automatic build_random_element();
    logic [2:0] tt;
    logic [7:0] frag;
    int         pay_n;
    int         cut;
    elem.delete();
    if ($urandom_range(99) < 8) tt = TT_UNKNOWN[$urandom_range(2)];
    else tt = TT_VALID[$urandom_range(4)];
    elem.push_back({5'($urandom), tt});
    unique case (tt)
      mpxp_pkg::TT_FULL: repeat (2) elem.push_back(8'($urandom));
      mpxp_pkg::TT_FRAG, mpxp_pkg::TT_FRAG_LAST: begin
        frag = ($urandom_range(2) == 0) ? 8'h00 : 8'($urandom);
        elem.push_back(frag);
        if (frag == 8'h00) repeat (4) elem.push_back(8'($urandom));
      end
      mpxp_pkg::TT_ABORT: if ($urandom_range(3) != 0) repeat (2) elem.push_back(8'($urandom));
      default: ;
    endcase
    // An abort that stops at its control byte gets no payload either.
    if (!(tt == mpxp_pkg::TT_ABORT && elem.size() == 1)) begin
      pay_n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
      repeat (pay_n) elem.push_back(8'($urandom));
    end
    if ($urandom_range(99) < 15) begin
      cut = $urandom_range(elem.size(), 1);
      while (elem.size() > cut) void'(elem.pop_back());
    end
  endtask

  task automatic test_random_elements(input int n_bytes);
    int sent;
    sent = 0;
    while (sent < n_bytes) begin
      build_random_element();
      send_element();
      sent += elem.size();
    end
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_header_types();
    test_abort_forms();
    test_unknown_types();
    test_early_end();
    test_long_payload();
    test_backpressure();

    // Random elements under each idling pattern in turn.
    send_idle_pct = 0;
    stall_pct     = 0;
    test_random_elements(100);
    send_idle_pct = 77;
    test_random_elements(100);
    send_idle_pct = 0;
    stall_pct     = 77;
    test_random_elements(100);
    send_idle_pct = 23;
    stall_pct     = 23;
    test_random_elements(100);

    if (mismatches == 0 && parsed_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
